@@ rtl/scp_pkg.sv @@
// shared types, widths and helpers for the sprite camera projection
package scp_pkg;

  localparam int NW         = 52;        // nx / ny width, signed
  localparam int YW         = NW - 1;    // positive depth numerator width
  localparam int DETW       = 37;        // determinant width, signed
  localparam int HDW        = 49;        // height times |det|
  localparam int QW         = 64;        // centre dividend and quotient
  localparam int SQW        = 17;        // span quotient
  localparam int RW         = NW + 1;    // centre partial remainder
  localparam int SRW        = NW;        // span partial remainder
  localparam int CW         = QW + 2;    // signed centre and box sums
  localparam int DIV_STAGES = QW;
  localparam int IDXW       = 8;

  typedef enum logic [IDXW-1:0] {
    REG_CAM_POS_X   = 8'd0,
    REG_CAM_POS_Y   = 8'd1,
    REG_CAM_DIR_X   = 8'd2,
    REG_CAM_DIR_Y   = 8'd3,
    REG_CAM_PLANE_X = 8'd4,
    REG_CAM_PLANE_Y = 8'd5,
    REG_VIEW_WIDTH  = 8'd6,
    REG_VIEW_HEIGHT = 8'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
    logic [12:0]        width;
    logic [12:0]        height;
  } cam_cfg_t;

  typedef struct packed {
    logic           vis;
    logic           neg;
    logic [YW-1:0]  ny;
    logic [QW-1:0]  num;
    logic [HDW-1:0] hdet;
  } div_in_t;

  typedef struct packed {
    logic           vis;
    logic           neg;
    logic [QW-1:0]  quo;
    logic [SQW-1:0] span;
  } div_out_t;

  function automatic logic [15:0] sat_s16(input logic signed [CW-1:0] v);
    logic [15:0] r;
    if (v > $signed(CW'(32767))) r = 16'h7fff;
    else if (v < -$signed(CW'(32768))) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] sat_u16(input logic [SQW-1:0] v);
    return v[SQW-1] ? 16'hffff : v[15:0];
  endfunction

endpackage

@@ rtl/scp_if.sv @@
// stream and configuration interfaces
interface scp_obj_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] obj_x;
  logic signed [31:0] obj_y;
  modport source (output valid, obj_x, obj_y, input ready);
  modport sink   (input valid, obj_x, obj_y, output ready);
endinterface

interface scp_res_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [15:0] center_x;
  logic [15:0]        span;
  logic signed [15:0] left_x;
  logic signed [15:0] top_y;
  logic signed [15:0] right_x;
  logic signed [15:0] bottom_y;
  modport source (output valid, visible, center_x, span, left_x, top_y, right_x, bottom_y,
                  input ready);
  modport sink   (input valid, visible, center_x, span, left_x, top_y, right_x, bottom_y,
                  output ready);
endinterface

interface scp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/scp_cfg.sv @@
// camera configuration register file
module scp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  scp_cfg_if.sink            cfg_i,
  output scp_pkg::cam_cfg_t  cam_o
);
  import scp_pkg::*;

  cam_cfg_t cam_q;

  assign cfg_i.ready = 1'b1;
  assign cam_o       = cam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q.pos_x   <= '0;
      cam_q.pos_y   <= '0;
      cam_q.dir_x   <= 18'sd65536;
      cam_q.dir_y   <= '0;
      cam_q.plane_x <= '0;
      cam_q.plane_y <= 18'sd43254;
      cam_q.width   <= 13'd640;
      cam_q.height  <= 13'd480;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CAM_POS_X:   cam_q.pos_x   <= cfg_i.data;
        REG_CAM_POS_Y:   cam_q.pos_y   <= cfg_i.data;
        REG_CAM_DIR_X:   cam_q.dir_x   <= cfg_i.data[17:0];
        REG_CAM_DIR_Y:   cam_q.dir_y   <= cfg_i.data[17:0];
        REG_CAM_PLANE_X: cam_q.plane_x <= cfg_i.data[17:0];
        REG_CAM_PLANE_Y: cam_q.plane_y <= cfg_i.data[17:0];
        REG_VIEW_WIDTH:  cam_q.width   <= cfg_i.data[12:0];
        REG_VIEW_HEIGHT: cam_q.height  <= cfg_i.data[12:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/scp_front.sv @@
// camera space transform, depth test and dividend set-up
module scp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  scp_pkg::cam_cfg_t  cam_i,
  input  logic               valid_i,
  input  logic signed [31:0] obj_x_i,
  input  logic signed [31:0] obj_y_i,
  output logic               valid_o,
  output scp_pkg::div_in_t   div_o
);
  import scp_pkg::*;

  logic signed [DETW-1:0] det_q;
  logic [6:0]             v_q;

  logic signed [32:0]     sx_q, sy_q;
  logic signed [50:0]     pa_q, pb_q, pc_q, pd_q;
  logic signed [NW-1:0]   nx_q, ny_q;
  logic                   vis4_q, vis5_q, vis6_q, vis7_q;
  logic [YW-1:0]          nyp4_q, nyp5_q, nyp6_q, nyp7_q;
  logic signed [NW-1:0]   nxp4_q;
  logic [DETW-2:0]        adet4_q;
  logic signed [NW:0]     s5_q;
  logic [HDW-1:0]         hdet5_q, hdet6_q, hdet7_q;
  logic signed [CW-1:0]   prod6_q;
  logic                   neg7_q;
  logic [QW-1:0]          num7_q;

  logic signed [55:0]     ny_ext, ny10, det_ext;
  logic                   vis4_d;
  logic signed [NW-1:0]   ny_neg, nx_neg;
  logic signed [DETW-1:0] det_neg;
  logic signed [CW-1:0]   prod6_d, prod_neg;

  // the user must see that the camera matrix only changes while idle; this block does not enforce it
  always_ff @(posedge clk_i) begin
    det_q <= DETW'(cam_i.plane_x * cam_i.dir_y) - DETW'(cam_i.dir_x * cam_i.plane_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  assign ny_ext  = {{(56-NW){ny_q[NW-1]}}, ny_q};
  assign ny10    = (ny_ext <<< 3) + (ny_ext <<< 1);
  assign det_ext = {{(56-DETW){det_q[DETW-1]}}, det_q};
  assign ny_neg  = -ny_q;
  assign nx_neg  = -nx_q;
  assign det_neg = -det_q;

  always_comb begin
    if (det_q > 0) vis4_d = ny10 > det_ext;
    else if (det_q < 0) vis4_d = ny10 < det_ext;
    else vis4_d = 1'b0;
  end

  assign prod6_d  = $signed({{(CW-12){1'b0}}, cam_i.width[12:1]}) *
                    $signed({{(CW-NW-1){s5_q[NW]}}, s5_q});
  assign prod_neg = -prod6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q    <= $signed({obj_x_i[31], obj_x_i}) - $signed({cam_i.pos_x[31], cam_i.pos_x});
      sy_q    <= $signed({obj_y_i[31], obj_y_i}) - $signed({cam_i.pos_y[31], cam_i.pos_y});
      pa_q    <= cam_i.dir_y * sx_q;
      pb_q    <= cam_i.dir_x * sy_q;
      pc_q    <= cam_i.plane_x * sy_q;
      pd_q    <= cam_i.plane_y * sx_q;
      nx_q    <= NW'(pa_q) - NW'(pb_q);
      ny_q    <= NW'(pc_q) - NW'(pd_q);
      // make the depth numerator positive
      vis4_q  <= vis4_d;
      nyp4_q  <= ny_q[NW-1] ? ny_neg[YW-1:0] : ny_q[YW-1:0];
      nxp4_q  <= ny_q[NW-1] ? nx_neg : nx_q;
      adet4_q <= det_q[DETW-1] ? det_neg[DETW-2:0] : det_q[DETW-2:0];
      // centre numerator is half width times (nx + ny)
      vis5_q  <= vis4_q;
      nyp5_q  <= nyp4_q;
      s5_q    <= $signed({nxp4_q[NW-1], nxp4_q}) + $signed({2'b00, nyp4_q});
      hdet5_q <= HDW'(cam_i.height) * HDW'(adet4_q);
      vis6_q  <= vis5_q;
      nyp6_q  <= nyp5_q;
      hdet6_q <= hdet5_q;
      prod6_q <= prod6_d;
      vis7_q  <= vis6_q;
      nyp7_q  <= nyp6_q;
      hdet7_q <= hdet6_q;
      neg7_q  <= prod6_q[CW-1];
      num7_q  <= prod6_q[CW-1] ? prod_neg[QW-1:0] : prod6_q[QW-1:0];
    end
  end

  assign valid_o    = v_q[6];
  assign div_o.vis  = vis7_q;
  assign div_o.neg  = neg7_q;
  assign div_o.ny   = nyp7_q;
  assign div_o.num  = num7_q;
  assign div_o.hdet = hdet7_q;

endmodule

@@ rtl/scp_div.sv @@
// pipelined restoring divider, one quotient bit per stage for both quotients
module scp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  scp_pkg::div_in_t   div_i,
  output logic               valid_o,
  output scp_pkg::div_out_t  div_o
);
  import scp_pkg::*;

  typedef struct packed {
    logic           vis;
    logic           neg;
    logic [YW-1:0]  ny;
    logic [RW-1:0]  rem;
    logic [QW-1:0]  qd;
    logic [SRW-1:0] srem;
    logic [SQW-1:0] sq;
  } div_st_t;

  div_st_t st_in;
  div_st_t st_q [DIV_STAGES];
  logic    v_q  [DIV_STAGES];

  assign st_in.vis  = div_i.vis;
  assign st_in.neg  = div_i.neg;
  assign st_in.ny   = div_i.ny;
  assign st_in.rem  = '0;
  assign st_in.qd   = div_i.num;
  // span quotient fits in its bits for a visible sprite, so the top part is below ny
  assign st_in.srem = SRW'(div_i.hdet[HDW-1:SQW]);
  assign st_in.sq   = div_i.hdet[SQW-1:0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_st_t        prev, nxt;
    logic           pv;
    logic [RW:0]    trial;
    logic [SRW:0]   strial;

    if (k == 0) begin : g_first
      assign prev = st_in;
      assign pv   = valid_i;
    end else begin : g_next
      assign prev = st_q[k-1];
      assign pv   = v_q[k-1];
    end

    assign trial  = {prev.rem, prev.qd[QW-1]} - {{(RW-YW+1){1'b0}}, prev.ny};
    assign strial = {prev.srem, prev.sq[SQW-1]} - {{(SRW-YW+1){1'b0}}, prev.ny};

    always_comb begin
      nxt     = prev;
      nxt.qd  = {prev.qd[QW-2:0], ~trial[RW]};
      nxt.rem = trial[RW] ? {prev.rem[RW-2:0], prev.qd[QW-1]} : trial[RW-1:0];
      if (k < SQW) begin
        nxt.sq   = {prev.sq[SQW-2:0], ~strial[SRW]};
        nxt.srem = strial[SRW] ? {prev.srem[SRW-2:0], prev.sq[SQW-1]} : strial[SRW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o    = v_q[DIV_STAGES-1];
  assign div_o.vis  = st_q[DIV_STAGES-1].vis;
  assign div_o.neg  = st_q[DIV_STAGES-1].neg;
  assign div_o.quo  = st_q[DIV_STAGES-1].qd;
  assign div_o.span = st_q[DIV_STAGES-1].sq;

endmodule

@@ rtl/scp_back.sv @@
// centre sign, bounding box and saturation, ending in the result register
module scp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  scp_pkg::cam_cfg_t  cam_i,
  input  logic               valid_i,
  input  scp_pkg::div_out_t  div_i,
  scp_res_if.source          res_o
);
  import scp_pkg::*;

  logic                 v1_q, vis1_q, valid_q;
  logic signed [CW-1:0] c1_q;
  logic [SQW-1:0]       span1_q;
  logic signed [CW-1:0] c_pos, half, hh;
  logic [15:0]          cx_d, sp_d, l_d, t_d, r_d, b_d;
  logic                 vis_q;
  logic [15:0]          cx_q, sp_q, l_q, t_q, r_q, b_q;

  assign c_pos = $signed({2'b00, div_i.quo});
  assign half  = $signed({{(CW-SQW+1){1'b0}}, span1_q[SQW-1:1]});
  assign hh    = $signed({{(CW-12){1'b0}}, cam_i.height[12:1]});

  assign cx_d = sat_s16(c1_q);
  assign sp_d = sat_u16(span1_q);
  assign l_d  = sat_s16(c1_q - half);
  assign t_d  = sat_s16(hh - half);
  assign r_d  = sat_s16(c1_q + half);
  assign b_d  = sat_s16(hh + half);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis1_q  <= div_i.vis;
      c1_q    <= div_i.neg ? -c_pos : c_pos;
      span1_q <= div_i.span;
      vis_q   <= vis1_q;
      // an invisible sprite gives an all-zero result
      cx_q    <= vis1_q ? cx_d : '0;
      sp_q    <= vis1_q ? sp_d : '0;
      l_q     <= vis1_q ? l_d  : '0;
      t_q     <= vis1_q ? t_d  : '0;
      r_q     <= vis1_q ? r_d  : '0;
      b_q     <= vis1_q ? b_d  : '0;
    end
  end

  assign res_o.valid    = valid_q;
  assign res_o.visible  = vis_q;
  assign res_o.center_x = cx_q;
  assign res_o.span     = sp_q;
  assign res_o.left_x   = l_q;
  assign res_o.top_y    = t_q;
  assign res_o.right_x  = r_q;
  assign res_o.bottom_y = b_q;

endmodule

@@ rtl/sprite_camera_projection.sv @@
// top level of the sprite camera projection pipeline
//
// Channels: obj_i takes one sprite world position (obj_x, obj_y, Q15.16) per
// transfer; res_o gives one result per sprite, in order: visible, center_x,
// span and the unclipped box left_x, top_y, right_x, bottom_y. cfg_i writes
// the camera registers by index; it is always ready and unknown indexes are
// dropped. Write the camera only while no sprite is in flight.
// Throughput: one sprite per cycle while res_o is not stalled. The pipeline is
// the 64 stages of the restoring divider (one quotient bit per stage) with
// 7 transform stages in front and 2 box stages behind.
// Stall: the whole pipeline holds while a result waits on res_o.ready, and
// obj_i.ready follows it; no sprite is lost or repeated.
// Reset: all stage valid bits clear and the camera returns to its default
// (facing +x, plane 0.66 on y, 640 x 480 screen); no clearing pass.
module sprite_camera_projection (
  input  logic       clk_i,
  input  logic       rst_ni,
  scp_cfg_if.sink    cfg_i,
  scp_obj_if.sink    obj_i,
  scp_res_if.source  res_o
);
  import scp_pkg::*;

  cam_cfg_t  cam;
  logic      en;
  logic      front_valid, div_valid;
  div_in_t   front_div;
  div_out_t  div_res;

  // the pipeline moves unless a finished result is held
  assign en          = !res_o.valid || res_o.ready;
  assign obj_i.ready = en;

  scp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cam_o  (cam)
  );

  scp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cam_i   (cam),
    .valid_i (obj_i.valid),
    .obj_x_i (obj_i.obj_x),
    .obj_y_i (obj_i.obj_y),
    .valid_o (front_valid),
    .div_o   (front_div)
  );

  scp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .div_i   (front_div),
    .valid_o (div_valid),
    .div_o   (div_res)
  );

  scp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cam_i   (cam),
    .valid_i (div_valid),
    .div_i   (div_res),
    .res_o   (res_o)
  );

endmodule

@@ tb/sv/sprite_camera_projection_checker.sv @@
`timescale 1ns / 100ps
// checker: watches the channels, predicts each sprite result and compares
module sprite_camera_projection_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  scp_cfg_if    cfg,
  scp_obj_if    obj,
  scp_res_if    res,
  output int    fail_count_o,
  output int    pending_o
);
  import scp_pkg::*;

  typedef struct packed {
    logic        visible;
    logic [15:0] center_x;
    logic [15:0] span;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
  } proj_t;

  cam_cfg_t camera;
  proj_t    expected_q[$];

  function automatic logic [15:0] clamp_s16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic proj_t project(cam_cfg_t c, logic signed [31:0] ox,
                                    logic signed [31:0] oy);
    proj_t  p;
    longint sx, sy, det, nx, ny, adet, span, hw, hh, half, prod, q, r, ctr;
    logic   vis;
    p = '0;
    sx = longint'(ox) - longint'(c.pos_x);
    sy = longint'(oy) - longint'(c.pos_y);
    det = longint'(c.plane_x) * c.dir_y - longint'(c.dir_x) * c.plane_y;
    nx = longint'(c.dir_y) * sx - longint'(c.dir_x) * sy;
    ny = longint'(c.plane_x) * sy - longint'(c.plane_y) * sx;
    if (det > 0) vis = (10 * ny > det);
    else if (det < 0) vis = (10 * ny < det);
    else vis = 1'b0;
    if (!vis) return p;
    if (ny < 0) begin
      ny = -ny;
      nx = -nx;
    end
    adet = det < 0 ? -det : det;
    span = (longint'(c.height) * adet) / ny;
    hw = longint'(c.width) >>> 1;
    prod = hw * nx;
    q = prod / ny;
    r = prod % ny;
    if (r < 0) begin
      q -= 1;
      r += ny;
    end
    ctr = hw + q;
    // truncate toward zero
    if (ctr < 0 && r != 0) ctr += 1;
    half = span >>> 1;
    hh = longint'(c.height) >>> 1;
    p.visible  = 1'b1;
    p.center_x = clamp_s16(ctr);
    p.span     = span > 65535 ? 16'hffff : span[15:0];
    p.left_x   = clamp_s16(ctr - half);
    p.top_y    = clamp_s16(hh - half);
    p.right_x  = clamp_s16(ctr + half);
    p.bottom_y = clamp_s16(hh + half);
    return p;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    proj_t want, got;
    if (!rst_ni) begin
      camera <= '{pos_x: 0, pos_y: 0, dir_x: 18'sd65536, dir_y: 0, plane_x: 0,
                  plane_y: 18'sd43254, width: 13'd640, height: 13'd480};
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CAM_POS_X:   camera.pos_x   <= cfg.data;
          REG_CAM_POS_Y:   camera.pos_y   <= cfg.data;
          REG_CAM_DIR_X:   camera.dir_x   <= cfg.data[17:0];
          REG_CAM_DIR_Y:   camera.dir_y   <= cfg.data[17:0];
          REG_CAM_PLANE_X: camera.plane_x <= cfg.data[17:0];
          REG_CAM_PLANE_Y: camera.plane_y <= cfg.data[17:0];
          REG_VIEW_WIDTH:  camera.width   <= cfg.data[12:0];
          REG_VIEW_HEIGHT: camera.height  <= cfg.data[12:0];
          default: ;
        endcase
      end
      if (obj.valid && obj.ready) expected_q.push_back(project(camera, obj.obj_x, obj.obj_y));
      if (res.valid && res.ready) begin
        got = '{res.visible, res.center_x, res.span, res.left_x, res.top_y,
                res.right_x, res.bottom_y};
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected vis=%b cx=%0d span=%0d box=%0d,%0d,%0d,%0d",
                     $time, want.visible, $signed(want.center_x), want.span,
                     $signed(want.left_x), $signed(want.top_y), $signed(want.right_x),
                     $signed(want.bottom_y));
            $display("%0t:          actual   vis=%b cx=%0d span=%0d box=%0d,%0d,%0d,%0d",
                     $time, got.visible, $signed(got.center_x), got.span,
                     $signed(got.left_x), $signed(got.top_y), $signed(got.right_x),
                     $signed(got.bottom_y));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/sprite_camera_projection_test.sv @@
`timescale 1ns / 100ps
// top of the sprite camera projection testbench: stimulus and verdict
module sprite_camera_projection_test;
  import scp_pkg::*;

  localparam int LATENCY   = 74;
  localparam int IDLE_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   drained;

  scp_cfg_if cfg();
  scp_obj_if obj();
  scp_res_if res();

  sprite_camera_projection i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .obj_i (obj),
    .res_o (res)
  );

  sprite_camera_projection_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg),
    .obj         (obj),
    .res         (res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((obj.valid && obj.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
        || !rst_ni || drained)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver stalls at random, with stall-free stretches
  initial begin
    int gap;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (($time / 4000) % 3 == 0) gap = 0;
      repeat (gap) begin
        @(posedge clk_i);
        res.ready <= 1'b0;
      end
      @(posedge clk_i);
      res.ready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_sprite(logic [31:0] x, logic [31:0] y, bit stall);
    int gap;
    gap = stall ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      obj.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    obj.valid <= 1'b1;
    obj.obj_x <= x;
    obj.obj_y <= y;
    do @(posedge clk_i); while (!obj.ready);
  endtask

  task automatic wait_drained();
    obj.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic load_camera(logic [31:0] px, logic [31:0] py, logic [17:0] dx,
                             logic [17:0] dy, logic [17:0] plx, logic [17:0] ply,
                             logic [12:0] w, logic [12:0] h);
    write_reg(REG_CAM_POS_X, px);
    write_reg(REG_CAM_POS_Y, py);
    write_reg(REG_CAM_DIR_X, {{14{dx[17]}}, dx});
    write_reg(REG_CAM_DIR_Y, {{14{dy[17]}}, dy});
    write_reg(REG_CAM_PLANE_X, {{14{plx[17]}}, plx});
    write_reg(REG_CAM_PLANE_Y, {{14{ply[17]}}, ply});
    write_reg(REG_VIEW_WIDTH, {19'd0, w});
    write_reg(REG_VIEW_HEIGHT, {19'd0, h});
  endtask

  // mostly sprites near the camera, some at full range
  function automatic logic [31:0] near_coord(logic [31:0] base);
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return base + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return base + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                  32'h0000_1999, 32'h0000_199a};
    logic [31:0] cpx, cpy;
    int phase;
    rst_ni    = 1'b0;
    drained   = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    obj.valid = 1'b0;
    obj.obj_x = '0;
    obj.obj_y = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset camera, field extremes and the depth threshold
    foreach (edge_vals[i]) send_sprite(edge_vals[i], 32'h0, 1'b0);
    foreach (edge_vals[i]) send_sprite(32'h0001_0000, edge_vals[i], 1'b0);
    send_sprite(32'h0000_199a, 32'h0000_0000, 1'b0);
    send_sprite(32'h0000_0001, 32'h7fff_0000, 1'b0);
    send_sprite(32'h0000_0001, 32'h8000_0000, 1'b0);
    send_sprite(32'hfff0_0000, 32'h0000_1000, 1'b0);
    // sender holds until everything has come back
    wait_drained();

    // zero determinant, then camera extremes
    load_camera(32'h0, 32'h0, 18'd65536, 18'd0, 18'd65536, 18'd0, 13'd640, 13'd480);
    send_sprite(32'h0003_0000, 32'h0001_0000, 1'b0);
    send_sprite(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    wait_drained();
    load_camera(32'h8000_0000, 32'h7fff_ffff, 18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000,
                13'h1fff, 13'h1fff);
    send_sprite(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_sprite(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_sprite(32'h0, 32'h0, 1'b0);
    wait_drained();
    load_camera(32'h0, 32'h0, 18'd1, 18'd0, 18'd0, 18'd1, 13'd0, 13'd0);
    send_sprite(32'h0100_0000, 32'h0000_0010, 1'b0);
    send_sprite(32'h0000_0002, 32'h0100_0000, 1'b0);
    wait_drained();

    // random phases, each on a fresh camera
    for (phase = 0; phase < 8; phase++) begin
      cpx = (phase % 3 == 0) ? $urandom() : $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      cpy = (phase % 3 == 0) ? $urandom() : $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      if (phase == 7)
        load_camera(cpx, cpy, 18'h20000, 18'h20000, 18'h1ffff, 18'h1ffff, 13'd1, 13'd4096);
      else
        load_camera(cpx, cpy, 18'($urandom()), 18'($urandom()), 18'($urandom()),
                    18'($urandom()),
                    13'((phase == 2) ? 4096 : $urandom_range(1, 4096)),
                    13'((phase == 4) ? $urandom() : $urandom_range(1, 4096)));
      repeat (72) send_sprite(near_coord(cpx), near_coord(cpy), (phase % 4) != 1);
      wait_drained();
    end

    drained = 1'b1;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
